// ===== rtl/core/dftb_pkg.sv =====
`default_nettype none
package dftb_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_ID_BITS = 16;
  localparam int ID_W        = 16;
  localparam int ADDR_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int IDX_W       = 5;
  localparam int ST_W        = 3;

  localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
  localparam logic [ST_W-1:0] STAT_DUP       = 3'd1;
  localparam logic [ST_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [ST_W-1:0] STAT_UNKNOWN   = 3'd3;
  localparam logic [ST_W-1:0] STAT_OUT_RANGE = 3'd4;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_BUILD = 1'b1;

  typedef struct packed {
    logic            start;
    logic            wr_en;
    logic [ID_W-1:0] wr_data;
  } dftb_mem_ctl_t;

  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] data;
    logic            done;
  } dftb_scan_t;

endpackage
`default_nettype wire

// ===== rtl/core/dftb_ring_mem.sv =====
`default_nettype none
// Identifier store plus scan sequencer: streams entries 0..count-1 one per cycle.
module dftb_ring_mem
  import dftb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dftb_mem_ctl_t ctl,
  output dftb_scan_t         scan,
  output logic [CNT_W-1:0]   count
);

  logic [ID_W-1:0]  mem [MAX_NODES];
  logic [ID_W-1:0]  rd_data_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             pend_r;
  logic             busy_r;
  logic             issue;
  logic             done;

  assign issue = busy_r && (idx_r < count_r);
  assign done  = busy_r && (idx_r == count_r) && !pend_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= ctl.wr_data;
    end
    rd_data_r <= mem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (ctl.start) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        busy_r <= 1'b1;
      end else begin
        pend_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign scan.vld  = pend_r;
  assign scan.data = rd_data_r;
  assign scan.done = done;
  assign count     = count_r;

endmodule
`default_nettype wire

// ===== rtl/core/dht_finger_table_builder_top.sv =====
`default_nettype none
// Channel  | Dir | tdata                                      | tuser      | tlast
// in_      | in  | [15:0] node_id                             | action     | -
// out_     | out | [4:0] finger_index, [20:5] successor_id    | [2:0] status | last
// cfg_     | in  | wr_data[4:0] id_bits, written when wr_en   | -          | -
//
// One item at a time. Each pass reads the n stored identifiers, one per cycle
// from the single memory read port.
// Add: one pass (none when out of range). Build: one membership pass plus one
// pass per finger (only the membership pass when the node is unknown).
// Synchronous active-low reset empties the table and sets id_bits to 8.
// A result waiting in the output register holds the sequencer, never the input.
module dht_finger_table_builder_top
  import dftb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,   // [4:0] id_bits
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,      // [15:0] node_id
  input  wire logic        in_tuser,      // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,     // [4:0] finger_index, [20:5] successor_id
  output logic [2:0]       out_tuser,     // [2:0] status
  output logic             out_tlast      // last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHK   = 2'd1;
  localparam logic [1:0] S_FSCAN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [4:0]       id_bits_r;
  logic             act_r, act_nxt;
  logic [ID_W-1:0]  node_r, node_nxt;
  logic [ID_W-1:0]  mask_r, mask_nxt;
  logic [IDX_W-1:0] m_r, m_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [ID_W-1:0]  target_r, target_nxt;
  logic             found_r, found_nxt;
  logic             have_lo_r, have_lo_nxt;
  logic [ID_W-1:0]  lowest_r, lowest_nxt;
  logic             have_best_r, have_best_nxt;
  logic [ID_W-1:0]  best_r, best_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [ID_W-1:0]  res_succ_r, res_succ_nxt;
  logic [ST_W-1:0]  res_stat_r, res_stat_nxt;
  logic             res_last_r, res_last_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [ID_W-1:0]  out_succ_r;
  logic [ST_W-1:0]  out_stat_r;
  logic             out_last_r;

  dftb_mem_ctl_t    mctl;
  dftb_scan_t       scan;
  logic [CNT_W-1:0] count;
  logic             in_acc;
  logic             out_free;
  logic             emit;
  logic [IDX_W-1:0] m_in;
  logic [ID_W-1:0]  mask_in;
  logic [ID_W:0]    span_in;

  dftb_ring_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .scan  (scan),
    .count (count)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit      = (state_r == S_EMIT) && out_free;

  // ring size clamp: 0 acts as 1, above the max as the max
  always_comb begin
    if (id_bits_r == 5'd0) begin
      m_in = IDX_W'(1);
    end else if (id_bits_r > 5'(MAX_ID_BITS)) begin
      m_in = IDX_W'(MAX_ID_BITS);
    end else begin
      m_in = id_bits_r;
    end
    span_in = (ID_W+1)'(1) << m_in;
    mask_in = ID_W'(span_in - (ID_W+1)'(1));
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    node_nxt      = node_r;
    mask_nxt      = mask_r;
    m_nxt         = m_r;
    fidx_nxt      = fidx_r;
    target_nxt    = target_r;
    found_nxt     = found_r;
    have_lo_nxt   = have_lo_r;
    lowest_nxt    = lowest_r;
    have_best_nxt = have_best_r;
    best_nxt      = best_r;
    res_idx_nxt   = res_idx_r;
    res_succ_nxt  = res_succ_r;
    res_stat_nxt  = res_stat_r;
    res_last_nxt  = res_last_r;
    mctl.start    = 1'b0;
    mctl.wr_en    = 1'b0;
    mctl.wr_data  = node_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt      = in_tuser;
          node_nxt     = in_tdata;
          m_nxt        = m_in;
          mask_nxt     = mask_in;
          found_nxt    = 1'b0;
          have_lo_nxt  = 1'b0;
          res_idx_nxt  = '0;
          res_succ_nxt = in_tdata;
          res_last_nxt = 1'b1;
          if (in_tuser == ACT_ADD && (in_tdata & ~mask_in) != '0) begin
            res_stat_nxt = STAT_OUT_RANGE;
            state_nxt    = S_EMIT;
          end else begin
            mctl.start = 1'b1;
            state_nxt  = S_CHK;
          end
        end
      end

      S_CHK: begin
        if (scan.vld) begin
          if (scan.data == node_r) begin
            found_nxt = 1'b1;
          end
          if (!have_lo_r || scan.data < lowest_r) begin
            lowest_nxt  = scan.data;
            have_lo_nxt = 1'b1;
          end
        end
        if (scan.done) begin
          if (act_r == ACT_ADD) begin
            if (found_r) begin
              res_stat_nxt = STAT_DUP;
            end else if (count >= CNT_W'(MAX_NODES)) begin
              res_stat_nxt = STAT_FULL;
            end else begin
              mctl.wr_en   = 1'b1;
              res_stat_nxt = STAT_OK;
            end
            state_nxt = S_EMIT;
          end else if (!found_r) begin
            res_stat_nxt = STAT_UNKNOWN;
            state_nxt    = S_EMIT;
          end else begin
            fidx_nxt      = IDX_W'(1);
            target_nxt    = (node_r + ID_W'(1)) & mask_r;
            have_best_nxt = 1'b0;
            mctl.start    = 1'b1;
            state_nxt     = S_FSCAN;
          end
        end
      end

      S_FSCAN: begin
        if (scan.vld && scan.data >= target_r &&
            (!have_best_r || scan.data < best_r)) begin
          best_nxt      = scan.data;
          have_best_nxt = 1'b1;
        end
        if (scan.done) begin
          res_idx_nxt  = fidx_r;
          res_succ_nxt = have_best_r ? best_r : lowest_r;
          res_stat_nxt = STAT_OK;
          res_last_nxt = (fidx_r == m_r);
          state_nxt    = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            // next finger i = fidx+1 targets node + 2^(i-1)
            fidx_nxt      = fidx_r + IDX_W'(1);
            target_nxt    = (node_r + ID_W'((ID_W+1)'(1) << fidx_r)) & mask_r;
            have_best_nxt = 1'b0;
            mctl.start    = 1'b1;
            state_nxt     = S_FSCAN;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      id_bits_r   <= 5'd8;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        id_bits_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    node_r      <= node_nxt;
    mask_r      <= mask_nxt;
    m_r         <= m_nxt;
    fidx_r      <= fidx_nxt;
    target_r    <= target_nxt;
    found_r     <= found_nxt;
    have_lo_r   <= have_lo_nxt;
    lowest_r    <= lowest_nxt;
    have_best_r <= have_best_nxt;
    best_r      <= best_nxt;
    res_idx_r   <= res_idx_nxt;
    res_succ_r  <= res_succ_nxt;
    res_stat_r  <= res_stat_nxt;
    res_last_r  <= res_last_nxt;
    if (emit) begin
      out_idx_r  <= res_idx_r;
      out_succ_r <= res_succ_r;
      out_stat_r <= res_stat_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_succ_r, out_idx_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
